[design/cfae_pkg.sv]
// Shared types, character codes and helpers for the CAN frame ASCII encoder.
// Depends on nothing; every other design file imports it.
package cfae_pkg;

    localparam logic [7:0] CHAR_STD_DATA = 8'h74;  // 't'
    localparam logic [7:0] CHAR_STD_RTR  = 8'h72;  // 'r'
    localparam logic [7:0] CHAR_EXT_DATA = 8'h54;  // 'T'
    localparam logic [7:0] CHAR_EXT_RTR  = 8'h52;  // 'R'
    localparam logic [7:0] CHAR_ZERO     = 8'h30;  // '0'
    localparam logic [7:0] CHAR_UPPER_A  = 8'h41;  // 'A'
    localparam logic [7:0] CHAR_LOWER_A  = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CHAR_LF       = 8'h0A;

    localparam logic [3:0] MAX_LENGTH    = 4'd8;
    localparam logic [3:0] LAST_STD_ID   = 4'd2;
    localparam logic [3:0] LAST_EXT_ID   = 4'd7;
    localparam logic [3:0] LAST_CNT      = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LETTER,
        ST_ID,
        ST_LEN,
        ST_DATA,
        ST_CNT,
        ST_CR,
        ST_LF
    } cfae_state_t;

    typedef struct packed {
        logic load;
        logic shift_id;
        logic shift_data;
        logic shift_cnt;
    } cfae_shift_ctl_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic lower);
        logic [7:0] base;
        if (nib < 4'd10) begin
            hex_char = CHAR_ZERO + {4'b0, nib};
        end
        else begin
            base     = lower ? CHAR_LOWER_A : CHAR_UPPER_A;
            hex_char = base + {4'b0, nib} - 8'd10;
        end
    endfunction

endpackage

[design/cfae_digit_shift.sv]
// Nibble shift registers for identifier, data bytes and frame counter.
// Depends on cfae_pkg for the shift control struct.
module cfae_digit_shift (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfae_pkg::cfae_shift_ctl_t ctl,
    input  logic [28:0]              frame_id,
    input  logic                     extended,
    input  logic [63:0]              payload,
    input  logic [15:0]              count_value,
    output logic [3:0]               id_nib,
    output logic [3:0]               data_nib,
    output logic [3:0]               cnt_nib
);
    import cfae_pkg::*;

    logic [31:0] id_reg;
    logic [63:0] data_reg;
    logic [15:0] cnt_reg;
    logic [31:0] id_load;
    logic [63:0] data_load;

    // Left-justify the identifier so its first digit sits in the top nibble.
    assign id_load = extended ? {3'b0, frame_id} : {1'b0, frame_id[10:0], 20'b0};

    // Byte 0 goes to the top so digits leave high nibble first, byte 0 first.
    genvar b;
    generate
        for (b = 0; b < 8; b++) begin : g_byte_swap
            assign data_load[63 - 8*b -: 8] = payload[8*b +: 8];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            id_reg   <= '0;
            data_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (ctl.load) begin
            id_reg   <= id_load;
            data_reg <= data_load;
            cnt_reg  <= count_value;
        end
        else begin
            if (ctl.shift_id) begin
                id_reg <= {id_reg[27:0], 4'b0};
            end
            if (ctl.shift_data) begin
                data_reg <= {data_reg[59:0], 4'b0};
            end
            if (ctl.shift_cnt) begin
                cnt_reg <= {cnt_reg[11:0], 4'b0};
            end
        end
    end

    assign id_nib   = id_reg[31:28];
    assign data_nib = data_reg[63:60];
    assign cnt_nib  = cnt_reg[15:12];

endmodule

[design/cfae_sequencer.sv]
// Line sequencer: walks the fields of one frame and builds each character.
// Depends on cfae_pkg for the state type, control struct and hex helper.
module cfae_sequencer (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      extended,
    input  logic                      remote,
    input  logic [3:0]                data_length,
    input  logic                      advance,
    input  logic [3:0]                id_nib,
    input  logic [3:0]                data_nib,
    input  logic [3:0]                cnt_nib,
    output logic                      idle,
    output logic                      emit,
    output logic [7:0]                char_value,
    output logic                      char_eol,
    output cfae_pkg::cfae_shift_ctl_t ctl
);
    import cfae_pkg::*;

    cfae_state_t state_reg, state_next;
    logic [3:0]  digit_reg, digit_next;
    logic        ext_reg, rtr_reg;
    logic [3:0]  len_reg;
    logic [3:0]  len_sat;
    logic [3:0]  last_data;
    logic [3:0]  last_id;

    assign len_sat   = (data_length > MAX_LENGTH) ? MAX_LENGTH : data_length;
    assign last_data = {len_reg[2:0], 1'b0} - 4'd1;
    assign last_id   = ext_reg ? LAST_EXT_ID : LAST_STD_ID;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            digit_reg <= '0;
            ext_reg   <= 1'b0;
            rtr_reg   <= 1'b0;
            len_reg   <= '0;
        end
        else begin
            state_reg <= state_next;
            digit_reg <= digit_next;
            if (start) begin
                ext_reg <= extended;
                rtr_reg <= remote;
                len_reg <= len_sat;
            end
        end
    end

    // Next state: advance one character whenever the output slot is free.
    always_comb begin
        state_next = state_reg;
        digit_next = digit_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_LETTER;
                    digit_next = '0;
                end
            end
            ST_LETTER: begin
                if (advance) begin
                    state_next = ST_ID;
                end
            end
            ST_ID: begin
                if (advance) begin
                    if (digit_reg == last_id) begin
                        state_next = ST_LEN;
                        digit_next = '0;
                    end
                    else begin
                        digit_next = digit_reg + 4'd1;
                    end
                end
            end
            ST_LEN: begin
                if (advance) begin
                    state_next = (len_reg == 4'd0) ? ST_CNT : ST_DATA;
                end
            end
            ST_DATA: begin
                if (advance) begin
                    if (digit_reg == last_data) begin
                        state_next = ST_CNT;
                        digit_next = '0;
                    end
                    else begin
                        digit_next = digit_reg + 4'd1;
                    end
                end
            end
            ST_CNT: begin
                if (advance) begin
                    if (digit_reg == LAST_CNT) begin
                        state_next = ST_CR;
                        digit_next = '0;
                    end
                    else begin
                        digit_next = digit_reg + 4'd1;
                    end
                end
            end
            ST_CR: begin
                if (advance) begin
                    state_next = ST_LF;
                end
            end
            ST_LF: begin
                if (advance) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: the character for the current field and the shift strobes.
    always_comb begin
        idle           = 1'b0;
        emit           = 1'b0;
        char_value     = CHAR_CR;
        char_eol       = 1'b0;
        ctl.load       = start;
        ctl.shift_id   = 1'b0;
        ctl.shift_data = 1'b0;
        ctl.shift_cnt  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                idle = 1'b1;
            end
            ST_LETTER: begin
                emit = advance;
                if (ext_reg) begin
                    char_value = rtr_reg ? CHAR_EXT_RTR : CHAR_EXT_DATA;
                end
                else begin
                    char_value = rtr_reg ? CHAR_STD_RTR : CHAR_STD_DATA;
                end
            end
            ST_ID: begin
                emit         = advance;
                char_value   = hex_char(id_nib, 1'b0);
                ctl.shift_id = advance;
            end
            ST_LEN: begin
                emit       = advance;
                char_value = CHAR_ZERO | {4'b0, (rtr_reg ? 4'd0 : len_reg)};
            end
            ST_DATA: begin
                emit           = advance;
                char_value     = hex_char(data_nib, 1'b0);
                ctl.shift_data = advance;
            end
            ST_CNT: begin
                emit          = advance;
                char_value    = hex_char(cnt_nib, 1'b1);
                ctl.shift_cnt = advance;
            end
            ST_CR: begin
                emit       = advance;
                char_value = CHAR_CR;
            end
            ST_LF: begin
                emit       = advance;
                char_value = CHAR_LF;
                char_eol   = 1'b1;
            end
            default: begin
                idle = 1'b0;
            end
        endcase
    end

endmodule

[design/can_frame_to_ascii_encoder.sv]
// Top level of the CAN frame ASCII encoder: frame counter and output register.
// Depends on cfae_pkg, cfae_digit_shift and cfae_sequencer.
//
// Usage:
//   Input channel (in_valid / in_ready) takes one received CAN frame:
//   frame_id, data_length, extended, remote and eight payload bytes.
//   Output channel (out_valid / out_ready) gives one ASCII character per
//   transfer; end_of_line marks the closing line feed.
//   A frame yields 11 to 32 characters: type letter, 3 or 8 identifier
//   digits, length digit, two digits per data byte, four lowercase
//   counter digits, CR and LF.
//   The sequencer emits one character per cycle through a nibble shift
//   path while the output register is free or out_ready is high; after
//   the input transfer it leaves idle and loads the type letter first.
//   in_ready is high only while the sequencer is idle; a new frame can be
//   taken in the cycle after the line feed is generated.
//   When out_ready is low the output register holds its character and the
//   sequencer waits; nothing is dropped.
//   Reset clears the frame counter (the first line carries 0001) and
//   returns the sequencer to idle with no character pending.
module can_frame_to_ascii_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [28:0] frame_id,
    input  logic [3:0]  data_length,
    input  logic        extended,
    input  logic        remote,
    input  logic [63:0] payload,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  ascii_char,
    output logic        end_of_line
);
    import cfae_pkg::*;

    logic [15:0]     frame_counter_reg, frame_counter_next;
    logic            out_valid_reg;
    logic [7:0]      ascii_char_reg;
    logic            end_of_line_reg;
    logic            start;
    logic            advance;
    logic            idle;
    logic            emit;
    logic [7:0]      char_value;
    logic            char_eol;
    logic [3:0]      id_nib, data_nib, cnt_nib;
    cfae_shift_ctl_t ctl;

    assign start              = in_valid && idle;
    assign advance            = !out_valid_reg || out_ready;
    assign frame_counter_next = frame_counter_reg + 16'd1;

    cfae_sequencer u_sequencer (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .extended    (extended),
        .remote      (remote),
        .data_length (data_length),
        .advance     (advance),
        .id_nib      (id_nib),
        .data_nib    (data_nib),
        .cnt_nib     (cnt_nib),
        .idle        (idle),
        .emit        (emit),
        .char_value  (char_value),
        .char_eol    (char_eol),
        .ctl         (ctl)
    );

    cfae_digit_shift u_digit_shift (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .frame_id    (frame_id),
        .extended    (extended),
        .payload     (payload),
        .count_value (frame_counter_next),
        .id_nib      (id_nib),
        .data_nib    (data_nib),
        .cnt_nib     (cnt_nib)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            frame_counter_reg <= '0;
        end
        else if (start) begin
            frame_counter_reg <= frame_counter_next;
        end
    end

    // Load a new character when the slot is free, drop the flag on transfer.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (emit) begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (emit) begin
            ascii_char_reg  <= char_value;
            end_of_line_reg <= char_eol;
        end
    end

    assign in_ready    = idle;
    assign out_valid   = out_valid_reg;
    assign ascii_char  = ascii_char_reg;
    assign end_of_line = end_of_line_reg;

endmodule

[design/cfae_checker.sv]
// Port-level checks for the CAN frame ASCII encoder, bound to the top level.
// Depends on cfae_pkg for character codes and on can_frame_to_ascii_encoder.
module cfae_port_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] ascii_char,
    input logic       end_of_line
);
    import cfae_pkg::*;

    // A stalled character holds until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ascii_char) && $stable(end_of_line))
        else $error("output character changed while stalled");

    // One frame at a time: no new frame right after one is taken.
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken twice in a row");

    // The line end flag rides only on the line feed.
    a_eol_lf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_line |-> ascii_char == CHAR_LF)
        else $error("end of line on a character other than line feed");

    // The line feed follows a transferred carriage return at once.
    a_cr_lf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && ascii_char == CHAR_CR |=> out_valid && end_of_line)
        else $error("carriage return not followed by line feed");

    // While a line is in flight the input stays closed.
    a_busy_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !end_of_line |-> !in_ready)
        else $error("input open in the middle of a line");

endmodule

bind can_frame_to_ascii_encoder cfae_port_checker u_cfae_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ascii_char  (ascii_char),
    .end_of_line (end_of_line)
);
